FILE: rtl/btm_pkg.sv
package btm_pkg;

  localparam int WINDOW = 3;

  localparam int RATE_W = 48;
  localparam int SENT_W = 32;
  localparam int NUM_W  = 55;
  localparam int DEN_W  = 32;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int TR_W   = $clog2(WINDOW) + 1;
  localparam int TOT_W  = RATE_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(NUM_W + 1);

  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [DEN_W-1:0]  den_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [TR_W-1:0]   trend_t;
  typedef logic [TOT_W-1:0]  tot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic [19:0] USEC_PER_SEC = 20'd1_000_000;
  localparam rate_t RATE_MAX = '1;

  localparam logic [2:0] CMD_SENT  = 3'd0;
  localparam logic [2:0] CMD_BUF   = 3'd1;
  localparam logic [2:0] CMD_LOST  = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;
  localparam logic [1:0] DIR_FLAT = 2'b00;

  typedef struct packed {
    logic push;
    logic scan;
  } win_ctrl_t;

endpackage

FILE: rtl/btm_div.sv
module btm_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  btm_pkg::num_t num,
  input  btm_pkg::den_t den,
  output logic          busy,
  output btm_pkg::num_t quo
);

  logic                          run;
  btm_pkg::cnt_t                 cnt;
  btm_pkg::num_t                 acc;
  btm_pkg::den_t                 rem;
  btm_pkg::den_t                 dv;
  logic [btm_pkg::DEN_W:0]       trial;
  logic [btm_pkg::DEN_W:0]       diff;
  logic                          ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, acc[btm_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= btm_pkg::cnt_t'(btm_pkg::NUM_W);
      acc <= num;
      rem <= '0;
      dv  <= den;
    end else if (run) begin
      rem <= ge ? diff[btm_pkg::DEN_W-1:0] : trial[btm_pkg::DEN_W-1:0];
      acc <= {acc[btm_pkg::NUM_W-2:0], ge};
      cnt <= cnt - btm_pkg::cnt_t'(1);
      if (cnt == btm_pkg::cnt_t'(1)) begin
        run <= 1'b0;
      end
    end
  end

  assign busy = run;
  assign quo  = acc;

endmodule

FILE: rtl/btm_win.sv
module btm_win (
  input  logic               clk,
  input  logic               rst,
  input  btm_pkg::win_ctrl_t ctrl,
  input  btm_pkg::rate_t     rate,
  output logic               busy,
  output btm_pkg::tot_t      total,
  output logic [1:0]         dir,
  output btm_pkg::fill_t     fill
);

  btm_pkg::rate_t  win [btm_pkg::WINDOW];
  btm_pkg::rate_t  prev;
  btm_pkg::rate_t  cur;
  btm_pkg::idx_t   idx;
  btm_pkg::trend_t trend;
  logic            run;
  logic            last;

  assign cur  = win[idx];
  assign last = (btm_pkg::fill_t'(idx) + btm_pkg::fill_t'(1)) == fill;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      for (int i = btm_pkg::WINDOW - 1; i > 0; i--) begin
        win[i] <= win[i-1];
      end
      win[0] <= rate;
    end
  end

  // one entry per cycle, newest to oldest
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      run  <= 1'b0;
    end else begin
      if (ctrl.push && fill != btm_pkg::fill_t'(btm_pkg::WINDOW)) begin
        fill <= fill + btm_pkg::fill_t'(1);
      end
      if (ctrl.scan) begin
        run   <= 1'b1;
        idx   <= '0;
        prev  <= win[0];
        total <= '0;
        trend <= '0;
      end else if (run) begin
        total <= total + btm_pkg::tot_t'(cur);
        if (cur > prev) begin
          trend <= trend - btm_pkg::trend_t'(1);
        end else if (cur < prev) begin
          trend <= trend + btm_pkg::trend_t'(1);
        end
        prev <= cur;
        if (last) begin
          run <= 1'b0;
        end else begin
          idx <= idx + btm_pkg::idx_t'(1);
        end
      end
    end
  end

  always_comb begin
    if (trend[btm_pkg::TR_W-1]) begin
      dir = btm_pkg::DIR_DOWN;
    end else if (trend != '0) begin
      dir = btm_pkg::DIR_UP;
    end else begin
      dir = btm_pkg::DIR_FLAT;
    end
  end

  assign busy = run;

endmodule

FILE: rtl/bitrate_trend_monitor.sv
// Bit-rate trend monitor.
// Input channel (in_valid/in_stall) carries one word per command: cmd and value.
// Sent-byte, buffer-size, lost-byte and clear words are taken whenever the block
// is idle and give no result. A tick word carries elapsed microseconds and gives
// one result word on the output channel (out_valid/out_stall): trend direction,
// window average, interval rate, latest buffer size and lost-byte total.
// A tick runs a multiply step, then a bit-serial divider for the rate, a push
// of that rate into the window, a walk over the window, newest to oldest, and
// the divider again for the average. The next word is taken no earlier than
// the cycle in which the result is valid.
// in_stall is high while a tick is in work; sample words wait for it.
// A finished result sits in the output register; the block takes new words
// while it waits there. A second tick result waits in the last step until the
// receiver takes the first.
// Reset clears the sums, the window fill count and the output valid; the
// block takes a word in the first cycle after reset.
module bitrate_trend_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [31:0]        value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [1:0]  direction,
  output logic [47:0]        average_rate,
  output logic [47:0]        current_rate,
  output logic [31:0]        buffer_size,
  output logic [47:0]        lost_total
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_RLOAD = 10'b0000000100,
    S_RDIV  = 10'b0000001000,
    S_PUSH  = 10'b0000010000,
    S_SLOAD = 10'b0000100000,
    S_SCAN  = 10'b0001000000,
    S_ALOAD = 10'b0010000000,
    S_ADIV  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic               in_acc;
  logic               out_load;
  logic [31:0]        sent_sum;
  logic [31:0]        latest_buffer;
  logic [47:0]        lost_sum;
  btm_pkg::den_t      elapsed;
  btm_pkg::num_t      prod;
  btm_pkg::rate_t     rate;
  logic [32:0]        sent_add;
  logic [48:0]        lost_add;

  logic               div_start;
  btm_pkg::num_t      div_num;
  btm_pkg::den_t      div_den;
  logic               div_busy;
  btm_pkg::num_t      div_quo;

  btm_pkg::win_ctrl_t win_ctrl;
  logic               win_busy;
  btm_pkg::tot_t      win_total;
  logic [1:0]         win_dir;
  btm_pkg::fill_t     win_fill;

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign sent_add = {1'b0, sent_sum} + {1'b0, value};
  assign lost_add = {1'b0, lost_sum} + 49'(value);

  assign div_start = (state == S_RLOAD) || (state == S_ALOAD);
  assign div_num   = (state == S_ALOAD) ? btm_pkg::num_t'(win_total) : prod;
  assign div_den   = (state == S_ALOAD) ? btm_pkg::den_t'(win_fill) : elapsed;

  assign win_ctrl = '{push: (state == S_PUSH), scan: (state == S_SLOAD)};

  btm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  btm_win u_win (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (win_ctrl),
    .rate  (rate),
    .busy  (win_busy),
    .total (win_total),
    .dir   (win_dir),
    .fill  (win_fill)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc && cmd == btm_pkg::CMD_TICK) state_next = S_MUL;
      S_MUL:   state_next = S_RLOAD;
      S_RLOAD: state_next = S_RDIV;
      S_RDIV:  if (!div_busy) state_next = S_PUSH;
      S_PUSH:  state_next = S_SLOAD;
      S_SLOAD: state_next = S_SCAN;
      S_SCAN:  if (!win_busy) state_next = S_ALOAD;
      S_ALOAD: state_next = S_ADIV;
      S_ADIV:  if (!div_busy) state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sent_sum      <= '0;
      latest_buffer <= '0;
      lost_sum      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        case (cmd)
          btm_pkg::CMD_SENT:  sent_sum <= sent_add[32] ? '1 : sent_add[31:0];
          btm_pkg::CMD_BUF:   latest_buffer <= value;
          btm_pkg::CMD_LOST:  lost_sum <= lost_add[48] ? '1 : lost_add[47:0];
          btm_pkg::CMD_TICK:  elapsed <= value;
          btm_pkg::CMD_CLEAR: begin
            lost_sum      <= '0;
            latest_buffer <= '0;
          end
          default: ;
        endcase
      end
      if (state == S_MUL) begin
        prod <= btm_pkg::num_t'({sent_sum, 3'b000}) * btm_pkg::num_t'(btm_pkg::USEC_PER_SEC);
      end
      // zero elapsed gives an all-ones quotient, caught by the saturation
      if (state == S_RDIV && !div_busy) begin
        rate <= (|div_quo[btm_pkg::NUM_W-1:btm_pkg::RATE_W]) ? btm_pkg::RATE_MAX
                                                            : div_quo[btm_pkg::RATE_W-1:0];
      end
      if (out_load) begin
        out_valid     <= 1'b1;
        direction     <= win_dir;
        average_rate  <= div_quo[btm_pkg::RATE_W-1:0];
        current_rate  <= rate;
        buffer_size   <= latest_buffer;
        lost_total    <= lost_sum;
        sent_sum      <= '0;
        latest_buffer <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idle_div_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word without a finished tick");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(win_fill) <= btm_pkg::WINDOW)
    else $error("window fill out of range");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |=> (win_fill != '0) && !win_busy)
    else $error("window empty after push");

endmodule
